[hw/rtl/tpsc_pkg.sv]
// Shared constants, types and helper functions of the two-point sensor calibration block.
// Used by every interface and module of the block; depends on nothing else.
`default_nettype none

package tpsc_pkg;

  // Sample format and fixed point format of the results.
  localparam int SAMPLE_WIDTH  = 16;
  localparam int FRACTION_BITS = 8;
  localparam int FIELD_W       = 16;
  localparam int OUT_W         = 24;

  // Calibration point widths.
  localparam int HUM_Y_W  = 8;
  localparam int TEMP_Y_W = 10;
  localparam int Y_W      = 10;

  // Configuration port format.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Datapath widths, derived from the sample, point and output widths, and the scale shifts.
  localparam int DIFF_W        = SAMPLE_WIDTH + 1;
  localparam int P_W           = Y_W + 1 + DIFF_W;
  localparam int N_W           = P_W + 1;
  localparam int NM_W          = N_W + FRACTION_BITS;
  localparam int HUM_SCALE_SH  = 1;
  localparam int TEMP_SCALE_SH = 3;
  localparam int SCALE_SH_MAX  = 3;
  localparam int SH_W          = $clog2(SCALE_SH_MAX + 1);
  localparam int DM_W          = DIFF_W + SCALE_SH_MAX;
  localparam int DIV_W         = (NM_W > DM_W + OUT_W) ? NM_W : DM_W + OUT_W;

  // Sum, magnitude and overflow stages, then one stage per quotient bit.
  localparam int LANE_STAGES = 3 + OUT_W;

  // Queue between the front and back parts; depth must be a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Output range limits.
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [OUT_W-1:0] OUT_MAX_MAG    = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN_MAG    = {1'b1, {(OUT_W-1){1'b0}}};

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUM_POINT0_X2   = 3'd0,
    REG_HUM_POINT1_X2   = 3'd1,
    REG_TEMP_POINT0_X8  = 3'd2,
    REG_TEMP_POINT1_X8  = 3'd3,
    REG_HUM_POINT0_RAW  = 3'd4,
    REG_HUM_POINT1_RAW  = 3'd5,
    REG_TEMP_POINT0_RAW = 3'd6,
    REG_TEMP_POINT1_RAW = 3'd7
  } reg_index_t;

  // Calibration register file contents.
  typedef struct packed {
    logic [HUM_Y_W-1:0]        hum_point0_x2;
    logic [HUM_Y_W-1:0]        hum_point1_x2;
    logic [TEMP_Y_W-1:0]       temp_point0_x8;
    logic [TEMP_Y_W-1:0]       temp_point1_x8;
    logic signed [FIELD_W-1:0] hum_point0_raw;
    logic signed [FIELD_W-1:0] hum_point1_raw;
    logic signed [FIELD_W-1:0] temp_point0_raw;
    logic signed [FIELD_W-1:0] temp_point1_raw;
  } calib_t;

  // Products of one channel as left by the front part.
  typedef struct packed {
    logic signed [P_W-1:0]    p0;
    logic signed [P_W-1:0]    p1;
    logic signed [DIFF_W-1:0] d;
    logic                     bad;
  } chan_prod_t;

  typedef struct packed {
    chan_prod_t hum;
    chan_prod_t temp;
  } front_item_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Takes the low SAMPLE_WIDTH bits of a field and sign extends them.
  function automatic logic signed [DIFF_W-1:0] sext_sample(input logic [FIELD_W-1:0] v);
    logic signed [SAMPLE_WIDTH-1:0] s;
    s = v[SAMPLE_WIDTH-1:0];
    return DIFF_W'(s);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tpsc_sample_if.sv]
// Request channel carrying one raw humidity and temperature sample pair.
// Depends on tpsc_pkg for the field widths.
`default_nettype none

interface tpsc_sample_if import tpsc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] raw_humidity;
  logic signed [FIELD_W-1:0] raw_temperature;

  modport source (output valid, output raw_humidity, output raw_temperature, input ready);
  modport sink   (input valid, input raw_humidity, input raw_temperature, output ready);
endinterface

`default_nettype wire

[hw/rtl/tpsc_result_if.sv]
// Request channel carrying one calibrated humidity and temperature result.
// Depends on tpsc_pkg for the field widths.
`default_nettype none

interface tpsc_result_if import tpsc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] humidity_value;
  logic signed [OUT_W-1:0] temperature_value;
  logic                    humidity_bad_calib;
  logic                    temperature_bad_calib;
  logic                    saturated;

  modport source (output valid, output humidity_value, output temperature_value,
                  output humidity_bad_calib, output temperature_bad_calib,
                  output saturated, input ready);
  modport sink   (input valid, input humidity_value, input temperature_value,
                  input humidity_bad_calib, input temperature_bad_calib,
                  input saturated, output ready);
endinterface

`default_nettype wire

[hw/rtl/tpsc_cfg_if.sv]
// Register write channel: register index and write data.
// Depends on tpsc_pkg for the field widths.
`default_nettype none

interface tpsc_cfg_if import tpsc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/two_point_sensor_calibration.sv]
// Two-point linear calibration of a humidity and temperature sensor. Each request on
// the sample channel carries one raw humidity and one raw temperature reading; each is
// mapped through the line set by its two calibration points and returned as a signed
// value with 8 fraction bits (1/256 percent rH, 1/256 degree C), truncated toward zero
// and clipped to 24 bits. A channel whose two raw points are equal reads 0 with its
// bad_calib bit set. The block takes one sample pair every cycle unless its queue is full;
// results come from the restoring divider in the back part, which produces one
// quotient bit per pipeline stage. A two-entry queue sits between the product stage and
// the divider, so input and output stall independently. The user must write the
// calibration registers only while no request is in flight; the block does not enforce it.
// Depends on tpsc_pkg, the three channel interfaces, tpsc_regs, tpsc_front,
// tpsc_queue and tpsc_back.
`default_nettype none

module two_point_sensor_calibration import tpsc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  tpsc_sample_if.sink   sample,
  tpsc_result_if.source result,
  tpsc_cfg_if.sink      cfg
);

  calib_t      calib;
  q_stat_t     q_stat;
  logic        q_push;
  logic        q_pop;
  front_item_t q_din;
  front_item_t q_dout;

  tpsc_regs u_regs (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .calib (calib)
  );

  tpsc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .calib  (calib),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_din  (q_din)
  );

  tpsc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_din),
    .pop  (q_pop),
    .dout (q_dout),
    .stat (q_stat)
  );

  tpsc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_dout (q_dout),
    .q_stat (q_stat),
    .q_pop  (q_pop),
    .result (result)
  );

`ifndef ASSERT_OFF
  // The front part never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("queue push while full");

  // The back part never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  // A channel with equal raw points reads zero.
  a_bad_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.humidity_bad_calib || result.temperature_bad_calib)) |->
    ((!result.humidity_bad_calib || result.humidity_value == '0) &&
     (!result.temperature_bad_calib || result.temperature_value == '0)))
    else $error("flagged channel does not read zero");

  // A clipped result sits at one of the range limits.
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.saturated) |->
    (result.humidity_value == OUT_MAX || result.humidity_value == OUT_MIN ||
     result.temperature_value == OUT_MAX || result.temperature_value == OUT_MIN))
    else $error("saturated result not at a limit");
`endif

endmodule

`default_nettype wire

[hw/rtl/tpsc_regs.sv]
// Calibration register file written through the configuration channel.
// Depends on tpsc_pkg and tpsc_cfg_if.
`default_nettype none

module tpsc_regs import tpsc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  tpsc_cfg_if.sink   cfg,
  output calib_t     calib
);

  // Writes are always taken.
  assign cfg.ready = 1'b1;

  // Register writes; wider data is cut to the register width.
  always_ff @(posedge clk) begin
    if (rst) begin
      calib.hum_point0_x2   <= '0;
      calib.hum_point1_x2   <= '0;
      calib.temp_point0_x8  <= '0;
      calib.temp_point1_x8  <= '0;
      calib.hum_point0_raw  <= '0;
      calib.hum_point1_raw  <= FIELD_W'(1);
      calib.temp_point0_raw <= '0;
      calib.temp_point1_raw <= FIELD_W'(1);
    end else if (cfg.valid) begin
      case (reg_index_t'(cfg.index))
        REG_HUM_POINT0_X2:   calib.hum_point0_x2   <= cfg.data[HUM_Y_W-1:0];
        REG_HUM_POINT1_X2:   calib.hum_point1_x2   <= cfg.data[HUM_Y_W-1:0];
        REG_TEMP_POINT0_X8:  calib.temp_point0_x8  <= cfg.data[TEMP_Y_W-1:0];
        REG_TEMP_POINT1_X8:  calib.temp_point1_x8  <= cfg.data[TEMP_Y_W-1:0];
        REG_HUM_POINT0_RAW:  calib.hum_point0_raw  <= cfg.data[FIELD_W-1:0];
        REG_HUM_POINT1_RAW:  calib.hum_point1_raw  <= cfg.data[FIELD_W-1:0];
        REG_TEMP_POINT0_RAW: calib.temp_point0_raw <= cfg.data[FIELD_W-1:0];
        REG_TEMP_POINT1_RAW: calib.temp_point1_raw <= cfg.data[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tpsc_front.sv]
// Front part: accepts sample pairs, flags equal raw points and forms the products.
// Depends on tpsc_pkg and tpsc_sample_if.
`default_nettype none

module tpsc_front import tpsc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  tpsc_sample_if.sink   sample,
  input  wire calib_t   calib,
  input  wire q_stat_t  q_stat,
  output logic          q_push,
  output front_item_t   q_din
);

  logic        front_valid;
  front_item_t item;

  // Both products of one channel: y0 * d and (y1 - y0) * (raw - x0).
  function automatic chan_prod_t chan_products(
    input logic [FIELD_W-1:0] raw,
    input logic [FIELD_W-1:0] x0_raw,
    input logic [FIELD_W-1:0] x1_raw,
    input logic [Y_W-1:0]     y0,
    input logic [Y_W-1:0]     y1
  );
    chan_prod_t             r;
    logic signed [DIFF_W-1:0] x0;
    logic signed [DIFF_W-1:0] dr;
    logic signed [Y_W:0]      y0s;
    logic signed [Y_W:0]      dy;
    x0    = sext_sample(x0_raw);
    r.d   = sext_sample(x1_raw) - x0;
    dr    = sext_sample(raw) - x0;
    y0s   = $signed({1'b0, y0});
    dy    = $signed({1'b0, y1}) - y0s;
    r.p0  = P_W'(y0s) * P_W'(r.d);
    r.p1  = P_W'(dy) * P_W'(dr);
    r.bad = (r.d == '0);
    return r;
  endfunction

  // The front stage empties into the queue whenever the queue has room.
  assign sample.ready = !front_valid || !q_stat.full;
  assign q_push       = front_valid && !q_stat.full;
  assign q_din        = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (sample.ready) begin
      front_valid <= sample.valid;
    end
  end

  // Product registers.
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      item.hum  <= chan_products(sample.raw_humidity, calib.hum_point0_raw,
                                 calib.hum_point1_raw, Y_W'(calib.hum_point0_x2),
                                 Y_W'(calib.hum_point1_x2));
      item.temp <= chan_products(sample.raw_temperature, calib.temp_point0_raw,
                                 calib.temp_point1_raw, Y_W'(calib.temp_point0_x8),
                                 Y_W'(calib.temp_point1_x8));
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tpsc_queue.sv]
// Short queue that decouples the front part from the divider pipeline.
// Depends on tpsc_pkg.
`default_nettype none

module tpsc_queue import tpsc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire front_item_t din,
  input  wire logic        pop,
  output front_item_t      dout,
  output q_stat_t          stat
);

  front_item_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign dout       = entries[rd_ptr];
  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

  // Pointers wrap naturally since the depth is a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tpsc_lane.sv]
// Back datapath of one channel: sum, magnitudes, restoring division one bit a stage,
// then sign and saturation. Depends on tpsc_pkg.
`default_nettype none

module tpsc_lane import tpsc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              adv,
  input  wire chan_prod_t        din,
  input  wire logic [SH_W-1:0]   scale_sh,
  output logic signed [OUT_W-1:0] value,
  output logic                   sat,
  output logic                   bad
);

  // Sum stage.
  logic signed [N_W-1:0]    s0_n;
  logic signed [DIFF_W-1:0] s0_d;
  logic                     s0_bad;

  // Magnitude stage.
  logic [NM_W-1:0] s1_nm;
  logic [DM_W-1:0] s1_dm;
  logic            s1_neg;
  logic            s1_bad;

  // Division stages; index 0 is the overflow check stage.
  logic [DIV_W-1:0] rem [OUT_W+1];
  logic [DM_W-1:0]  dv  [OUT_W+1];
  logic [OUT_W-1:0] q   [OUT_W+1];
  logic             neg [OUT_W+1];
  logic             bd  [OUT_W+1];
  logic             ovf [OUT_W+1];

  logic [DIV_W-1:0] div_sh   [OUT_W];
  logic [DIV_W-1:0] rem_next [OUT_W];
  logic             take     [OUT_W];

  logic [N_W-1:0]    nmag;
  logic [DIFF_W-1:0] dmag;
  logic [OUT_W-1:0]  mag;

  // Magnitudes of numerator and divisor.
  always_comb begin
    nmag = s0_n[N_W-1] ? N_W'(-s0_n) : N_W'(s0_n);
    dmag = s0_d[DIFF_W-1] ? DIFF_W'(-s0_d) : DIFF_W'(s0_d);
  end

  // One quotient bit per stage, most significant first.
  always_comb begin
    for (int j = 0; j < OUT_W; j++) begin
      div_sh[j]   = DIV_W'(dv[j]) << (OUT_W - 1 - j);
      take[j]     = (rem[j] >= div_sh[j]);
      rem_next[j] = take[j] ? rem[j] - div_sh[j] : rem[j];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_n   <= N_W'(din.p0) + N_W'(din.p1);
      s0_d   <= din.d;
      s0_bad <= din.bad;

      s1_nm  <= NM_W'(nmag) << FRACTION_BITS;
      s1_dm  <= DM_W'(dmag) << scale_sh;
      s1_neg <= s0_n[N_W-1] ^ s0_d[DIFF_W-1];
      s1_bad <= s0_bad;

      // A quotient of 2^OUT_W or more cannot fit the output at all.
      rem[0] <= DIV_W'(s1_nm);
      dv[0]  <= s1_dm;
      q[0]   <= '0;
      neg[0] <= s1_neg;
      bd[0]  <= s1_bad;
      ovf[0] <= (DIV_W'(s1_nm) >= (DIV_W'(s1_dm) << OUT_W));

      for (int j = 0; j < OUT_W; j++) begin
        rem[j+1] <= rem_next[j];
        dv[j+1]  <= dv[j];
        q[j+1]   <= {q[j][OUT_W-2:0], take[j]};
        neg[j+1] <= neg[j];
        bd[j+1]  <= bd[j];
        ovf[j+1] <= ovf[j];
      end
    end
  end

  // Sign, clipping and the equal-points case.
  always_comb begin
    mag = q[OUT_W];
    bad = bd[OUT_W];
    sat = !bd[OUT_W] && (ovf[OUT_W] ||
          (neg[OUT_W] ? (mag > OUT_MIN_MAG) : (mag > OUT_MAX_MAG)));
    if (bd[OUT_W]) begin
      value = '0;
    end else if (sat) begin
      value = neg[OUT_W] ? OUT_MIN : OUT_MAX;
    end else begin
      value = neg[OUT_W] ? -$signed(mag) : $signed(mag);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tpsc_back.sv]
// Back part: pulls items from the queue through both channel lanes into the result register.
// Depends on tpsc_pkg, tpsc_lane and tpsc_result_if.
`default_nettype none

module tpsc_back import tpsc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire front_item_t q_dout,
  input  wire q_stat_t     q_stat,
  output logic             q_pop,
  tpsc_result_if.source    result
);

  logic                     adv;
  logic [LANE_STAGES-1:0]   stage_valid;
  logic signed [OUT_W-1:0]  hum_value;
  logic signed [OUT_W-1:0]  temp_value;
  logic                     hum_sat;
  logic                     temp_sat;
  logic                     hum_bad;
  logic                     temp_bad;

  // The pipeline moves whenever the result register is free or being emptied.
  assign adv   = !result.valid || result.ready;
  assign q_pop = adv && !q_stat.empty;

  tpsc_lane u_hum_lane (
    .clk      (clk),
    .adv      (adv),
    .din      (q_dout.hum),
    .scale_sh (SH_W'(HUM_SCALE_SH)),
    .value    (hum_value),
    .sat      (hum_sat),
    .bad      (hum_bad)
  );

  tpsc_lane u_temp_lane (
    .clk      (clk),
    .adv      (adv),
    .din      (q_dout.temp),
    .scale_sh (SH_W'(TEMP_SCALE_SH)),
    .value    (temp_value),
    .sat      (temp_sat),
    .bad      (temp_bad)
  );

  // Occupancy of the lane stages and of the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= '0;
      result.valid <= 1'b0;
    end else if (adv) begin
      stage_valid  <= {stage_valid[LANE_STAGES-2:0], q_pop};
      result.valid <= stage_valid[LANE_STAGES-1];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (adv) begin
      result.humidity_value        <= hum_value;
      result.temperature_value     <= temp_value;
      result.humidity_bad_calib    <= hum_bad;
      result.temperature_bad_calib <= temp_bad;
      result.saturated             <= hum_sat || temp_sat;
    end
  end

endmodule

`default_nettype wire

[verif/two_point_sensor_calibration_test.sv]
// Self-checking test of the two-point sensor calibration block: directed extremes,
// then randomised calibration settings and sample pairs, with random stalls on both sides.
// Depends on tpsc_pkg, the three channel interfaces and two_point_sensor_calibration.
module two_point_sensor_calibration_test;
  import tpsc_pkg::*;

  localparam longint HUM_SCALE       = 2;
  localparam longint TEMP_SCALE      = 8;
  localparam longint OUT_TOP         = (longint'(1) << (OUT_W - 1)) - 1;
  localparam longint OUT_BOTTOM      = -(longint'(1) << (OUT_W - 1));
  localparam logic [FIELD_W-1:0] FIELD_MIN = 16'h8000;
  localparam logic [FIELD_W-1:0] FIELD_MAX = 16'h7FFF;
  localparam int RANDOM_PHASES       = 10;
  localparam int PHASE_ITEMS         = 193;
  localparam int HOLD_OFF_CYCLES     = 100;
  localparam int DRAIN_CYCLES        = 40;

  typedef logic [CFG_DATA_W-1:0] setting_t [8];

  // One calibrated reading as the block should return it.
  typedef struct {
    logic signed [OUT_W-1:0] humidity;
    logic signed [OUT_W-1:0] temperature;
    logic                    hum_bad;
    logic                    temp_bad;
    logic                    saturated;
  } reading_t;

  // Holds the calibration registers and the readings still owed by the block.
  class calibration_book;
    calib_t   regs;
    reading_t awaited[$];
    int failures;
    int samples;
    int results;
    int clipped;
    int flagged;

    function void reset_registers();
      regs = '0;
      regs.hum_point1_raw  = FIELD_W'(1);
      regs.temp_point1_raw = FIELD_W'(1);
    endfunction

    // Register writes keep only the bits that the register holds.
    function void write_register(reg_index_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_HUM_POINT0_X2:   regs.hum_point0_x2   = data[HUM_Y_W-1:0];
        REG_HUM_POINT1_X2:   regs.hum_point1_x2   = data[HUM_Y_W-1:0];
        REG_TEMP_POINT0_X8:  regs.temp_point0_x8  = data[TEMP_Y_W-1:0];
        REG_TEMP_POINT1_X8:  regs.temp_point1_x8  = data[TEMP_Y_W-1:0];
        REG_HUM_POINT0_RAW:  regs.hum_point0_raw  = data[FIELD_W-1:0];
        REG_HUM_POINT1_RAW:  regs.hum_point1_raw  = data[FIELD_W-1:0];
        REG_TEMP_POINT0_RAW: regs.temp_point0_raw = data[FIELD_W-1:0];
        REG_TEMP_POINT1_RAW: regs.temp_point1_raw = data[FIELD_W-1:0];
        default: ;
      endcase
    endfunction

    // Low SAMPLE_WIDTH bits of a field as a signed number.
    function longint as_sample(logic [FIELD_W-1:0] v);
      longint w;
      w = longint'(v[SAMPLE_WIDTH-1:0]);
      if (v[SAMPLE_WIDTH-1]) w -= longint'(1) << SAMPLE_WIDTH;
      return w;
    endfunction

    // Straight line through two points, one truncating division, then clipping.
    function void map_channel(logic [FIELD_W-1:0] raw, logic [FIELD_W-1:0] x0,
                              logic [FIELD_W-1:0] x1, longint y0, longint y1,
                              longint scale, output logic signed [OUT_W-1:0] value,
                              output logic bad, output logic sat);
      longint a, span, num, quo;
      a    = as_sample(x0);
      span = as_sample(x1) - a;
      bad  = 1'b0;
      sat  = 1'b0;
      value = '0;
      if (span == 0) begin
        bad = 1'b1;
        return;
      end
      num = (y0 * span + (y1 - y0) * (as_sample(raw) - a)) * (longint'(1) << FRACTION_BITS);
      quo = num / (scale * span);
      if (quo > OUT_TOP) begin
        quo = OUT_TOP;
        sat = 1'b1;
      end else if (quo < OUT_BOTTOM) begin
        quo = OUT_BOTTOM;
        sat = 1'b1;
      end
      value = quo[OUT_W-1:0];
    endfunction

    // An accepted request: work out the reading it must produce.
    function void note_sample(logic [FIELD_W-1:0] hum, logic [FIELD_W-1:0] temp);
      reading_t e;
      logic hsat, tsat;
      map_channel(hum, regs.hum_point0_raw, regs.hum_point1_raw,
                  longint'(regs.hum_point0_x2), longint'(regs.hum_point1_x2), HUM_SCALE,
                  e.humidity, e.hum_bad, hsat);
      map_channel(temp, regs.temp_point0_raw, regs.temp_point1_raw,
                  longint'(regs.temp_point0_x8), longint'(regs.temp_point1_x8), TEMP_SCALE,
                  e.temperature, e.temp_bad, tsat);
      e.saturated = hsat | tsat;
      samples++;
      if (e.saturated) clipped++;
      if (e.hum_bad || e.temp_bad) flagged++;
      awaited.push_back(e);
    endfunction

    // A returned reading is compared with the oldest one owed.
    function void check_result(logic signed [OUT_W-1:0] hv, logic signed [OUT_W-1:0] tv,
                               logic hb, logic tb, logic sat);
      reading_t e;
      results++;
      if (awaited.size() == 0) begin
        $error("result returned with no request awaiting it");
        failures++;
        return;
      end
      e = awaited.pop_front();
      if (hv !== e.humidity) begin
        $error("humidity_value: expected %0d, got %0d", e.humidity, hv);
        failures++;
      end
      if (tv !== e.temperature) begin
        $error("temperature_value: expected %0d, got %0d", e.temperature, tv);
        failures++;
      end
      if (hb !== e.hum_bad) begin
        $error("humidity_bad_calib: expected %0b, got %0b", e.hum_bad, hb);
        failures++;
      end
      if (tb !== e.temp_bad) begin
        $error("temperature_bad_calib: expected %0b, got %0b", e.temp_bad, tb);
        failures++;
      end
      if (sat !== e.saturated) begin
        $error("saturated: expected %0b, got %0b", e.saturated, sat);
        failures++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic calm;
  logic hold_off_request;
  int   settings_used;
  calibration_book book;

  tpsc_sample_if sample_ch ();
  tpsc_result_if result_ch ();
  tpsc_cfg_if    cfg_ch ();

  two_point_sensor_calibration u_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #5 clk = ~clk;

  // Small signed offset, wrapped to the field width.
  function automatic logic [FIELD_W-1:0] nudge(input int reach);
    return FIELD_W'($urandom_range(0, 2 * reach)) - FIELD_W'(reach);
  endfunction

  // Calibration level with random upper bits, often at one end of its range.
  function automatic logic [CFG_DATA_W-1:0] pick_level(input int width);
    logic [CFG_DATA_W-1:0] v, ones;
    v    = CFG_DATA_W'($urandom);
    ones = (CFG_DATA_W'(1) << width) - CFG_DATA_W'(1);
    case ($urandom_range(0, 3))
      0: v = v & ~ones;
      1: v = v | ones;
      default: ;
    endcase
    return v;
  endfunction

  // Raw calibration points: equal, close together, at the extremes, or anywhere.
  function automatic void pick_points(output logic [FIELD_W-1:0] p0,
                                      output logic [FIELD_W-1:0] p1);
    p0 = FIELD_W'($urandom);
    case ($urandom_range(0, 5))
      0: p1 = p0;
      1: p1 = p0 + nudge(8);
      2: begin
        if ($urandom_range(0, 1) == 0) begin
          p0 = FIELD_MIN;
          p1 = FIELD_MAX;
        end else begin
          p0 = FIELD_MAX;
          p1 = FIELD_MIN;
        end
      end
      default: p1 = FIELD_W'($urandom);
    endcase
  endfunction

  function automatic void pick_setting(output setting_t s);
    s[REG_HUM_POINT0_X2]  = pick_level(HUM_Y_W);
    s[REG_HUM_POINT1_X2]  = pick_level(HUM_Y_W);
    s[REG_TEMP_POINT0_X8] = pick_level(TEMP_Y_W);
    s[REG_TEMP_POINT1_X8] = pick_level(TEMP_Y_W);
    pick_points(s[REG_HUM_POINT0_RAW], s[REG_HUM_POINT1_RAW]);
    pick_points(s[REG_TEMP_POINT0_RAW], s[REG_TEMP_POINT1_RAW]);
  endfunction

  // Raw sample near one of the channel's points, or anywhere in the field.
  function automatic logic [FIELD_W-1:0] pick_raw(input logic [FIELD_W-1:0] p0,
                                                  input logic [FIELD_W-1:0] p1);
    case ($urandom_range(0, 3))
      0: return p0 + nudge(1000);
      1: return p1 + nudge(1000);
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  // Offer one sample pair and wait for it to be taken, then maybe pause.
  task automatic send_pair(input logic [FIELD_W-1:0] hum, input logic [FIELD_W-1:0] temp);
    @(negedge clk);
    sample_ch.valid           <= 1'b1;
    sample_ch.raw_humidity    <= hum;
    sample_ch.raw_temperature <= temp;
    do @(posedge clk); while (!sample_ch.ready);
    book.note_sample(hum, temp);
    if (!calm && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 2)) @(negedge clk);
    end
  endtask

  // Stop offering and wait until every owed reading has come back.
  task automatic settle();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (book.pending() != 0) @(negedge clk);
  endtask

  // Write all eight registers back to back while the block is idle.
  task automatic write_calibration(input setting_t s);
    reg_index_t idx;
    settle();
    idx = idx.first();
    do begin
      @(negedge clk);
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data  <= s[idx];
      do @(posedge clk); while (!cfg_ch.ready);
      book.write_register(idx, s[idx]);
      idx = idx.next();
    end while (idx != idx.first());
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // Both channels at zero and at the ends of the sample range.
  task automatic directed_pairs();
    send_pair('0, '0);
    send_pair(FIELD_MIN, FIELD_MAX);
    send_pair(FIELD_MAX, FIELD_MIN);
    send_pair(FIELD_MIN, FIELD_MIN);
    send_pair(FIELD_MAX, FIELD_MAX);
  endtask

  // Main stimulus: directed settings first, then random phases.
  initial begin
    setting_t s;
    int phase;
    rst                       = 1'b1;
    calm                      = 1'b0;
    hold_off_request          = 1'b0;
    settings_used             = 0;
    sample_ch.valid           = 1'b0;
    sample_ch.raw_humidity    = '0;
    sample_ch.raw_temperature = '0;
    cfg_ch.valid              = 1'b0;
    cfg_ch.index              = REG_HUM_POINT0_X2;
    cfg_ch.data               = '0;
    book = new();
    book.reset_registers();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Calibration as left by reset.
    directed_pairs();
    // Full-range points, both lines rising, temperature points given high end first; masked upper bits.
    s = '{16'hFF00, 16'h00FF, 16'hFFFF, 16'hFC00, FIELD_MIN, FIELD_MAX, FIELD_MAX, FIELD_MIN};
    write_calibration(s);
    directed_pairs();
    // Raw points one apart, so the extremes clip in both directions.
    s = '{16'h0000, 16'hFFFF, 16'h03FF, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 16'h0000};
    write_calibration(s);
    directed_pairs();
    // Humidity points equal while temperature clips.
    s = '{16'h0050, 16'h00C8, 16'h0000, 16'h03FF, 16'h1234, 16'h1234, 16'h0000, 16'h0001};
    write_calibration(s);
    directed_pairs();
    // Temperature points equal, humidity on an ordinary line.
    s = '{16'h003C, 16'h00B4, 16'h00C8, 16'h0190, 16'hEC78, 16'h2710, FIELD_MIN, FIELD_MIN};
    write_calibration(s);
    directed_pairs();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      pick_setting(s);
      write_calibration(s);
      calm = (phase == RANDOM_PHASES - 1);
      // Once, hold the result side off so that the block fills and stalls its input.
      if (phase == 2) hold_off_request = 1'b1;
      repeat (PHASE_ITEMS) begin
        send_pair(pick_raw(s[REG_HUM_POINT0_RAW], s[REG_HUM_POINT1_RAW]),
                  pick_raw(s[REG_TEMP_POINT0_RAW], s[REG_TEMP_POINT1_RAW]));
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (book.pending() != 0) begin
      $error("%0d readings never returned", book.pending());
      book.failures++;
    end
    $display("Checked %0d results from %0d sample pairs over %0d calibration settings.",
             book.results, book.samples, settings_used);
    $display("%0d results were clipped and %0d had a channel with equal raw points.",
             book.clipped, book.flagged);
    if (book.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result side: ready with random short stalls, and one long hold-off on request.
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_request) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_request = 1'b0;
        result_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Every reading handed over is checked against the oldest one owed.
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      book.check_result(result_ch.humidity_value, result_ch.temperature_value,
                        result_ch.humidity_bad_calib, result_ch.temperature_bad_calib,
                        result_ch.saturated);
    end
  end

  // Give up if the run hangs.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end
endmodule
